### hdl/mips_integer_execute_unit_assert.svh
// ----------------------------------------------------------------------------
// execute unit assertion macros
// shared concurrent assertion forms for the execute unit
// ----------------------------------------------------------------------------
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MIE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("execute unit assertion failed");

// condition never holds
`define MIE_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("execute unit assertion failed");

`endif

### hdl/mie_pkg.sv
// ----------------------------------------------------------------------------
// execute unit package
// operation codes, fault codes, state and shared structs
// ----------------------------------------------------------------------------
package mie_pkg;

	localparam logic [5:0] K_ADDU  = 6'd0;
	localparam logic [5:0] K_ADD   = 6'd1;
	localparam logic [5:0] K_ADDIU = 6'd2;
	localparam logic [5:0] K_ADDI  = 6'd3;
	localparam logic [5:0] K_AND   = 6'd4;
	localparam logic [5:0] K_ANDI  = 6'd5;
	localparam logic [5:0] K_CLO   = 6'd6;
	localparam logic [5:0] K_CLZ   = 6'd7;
	localparam logic [5:0] K_DIVU  = 6'd8;
	localparam logic [5:0] K_DIV   = 6'd9;
	localparam logic [5:0] K_MULT  = 6'd10;
	localparam logic [5:0] K_MULTU = 6'd11;
	localparam logic [5:0] K_MUL   = 6'd12;
	localparam logic [5:0] K_MADD  = 6'd13;
	localparam logic [5:0] K_MADDU = 6'd14;
	localparam logic [5:0] K_MSUB  = 6'd15;
	localparam logic [5:0] K_MSUBU = 6'd16;
	localparam logic [5:0] K_NOR   = 6'd17;
	localparam logic [5:0] K_OR    = 6'd18;
	localparam logic [5:0] K_ORI   = 6'd19;
	localparam logic [5:0] K_SLL   = 6'd20;
	localparam logic [5:0] K_SLLV  = 6'd21;
	localparam logic [5:0] K_SRA   = 6'd22;
	localparam logic [5:0] K_SRAV  = 6'd23;
	localparam logic [5:0] K_SRL   = 6'd24;
	localparam logic [5:0] K_SRLV  = 6'd25;
	localparam logic [5:0] K_SUBU  = 6'd26;
	localparam logic [5:0] K_SUB   = 6'd27;
	localparam logic [5:0] K_XOR   = 6'd28;
	localparam logic [5:0] K_XORI  = 6'd29;
	localparam logic [5:0] K_LUI   = 6'd30;
	localparam logic [5:0] K_SLTU  = 6'd31;
	localparam logic [5:0] K_SLT   = 6'd32;
	localparam logic [5:0] K_SLTIU = 6'd33;
	localparam logic [5:0] K_SLTI  = 6'd34;
	localparam logic [5:0] K_TEQ   = 6'd35;
	localparam logic [5:0] K_TEQI  = 6'd36;
	localparam logic [5:0] K_TNE   = 6'd37;
	localparam logic [5:0] K_TNEI  = 6'd38;
	localparam logic [5:0] K_TGEU  = 6'd39;
	localparam logic [5:0] K_TGEIU = 6'd40;
	localparam logic [5:0] K_TGE   = 6'd41;
	localparam logic [5:0] K_TGEI  = 6'd42;
	localparam logic [5:0] K_TLTU  = 6'd43;
	localparam logic [5:0] K_TLTIU = 6'd44;
	localparam logic [5:0] K_TLT   = 6'd45;
	localparam logic [5:0] K_TLTI  = 6'd46;
	localparam logic [5:0] K_MFHI  = 6'd47;
	localparam logic [5:0] K_MFLO  = 6'd48;
	localparam logic [5:0] K_MTHI  = 6'd49;
	localparam logic [5:0] K_MTLO  = 6'd50;

	localparam logic [1:0] F_NONE  = 2'd0;
	localparam logic [1:0] F_OVF   = 2'd1;
	localparam logic [1:0] F_TRAP  = 2'd2;
	localparam logic [1:0] F_DIVZ  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_WB
	} state_t;

	typedef struct packed {
		logic        wv;
		logic [4:0]  widx;
		logic [31:0] wval;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [1:0]  fault;
	} res_t;

	typedef struct packed {
		logic        start;
		logic        sgn;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

### hdl/mie_if.sv
// ----------------------------------------------------------------------------
// execute unit channels
// instruction and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mie_instr_if;
	logic        valid;
	logic        ready;
	logic [5:0]  kind;
	logic [4:0]  src_a_index;
	logic [4:0]  src_b_index;
	logic [4:0]  dest_index;
	logic [15:0] immediate;
	logic [4:0]  shift_amount;

	modport source (output valid, kind, src_a_index, src_b_index, dest_index,
		immediate, shift_amount, input ready);
	modport sink (input valid, kind, src_a_index, src_b_index, dest_index,
		immediate, shift_amount, output ready);
endinterface

interface mie_result_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [4:0]  write_index;
	logic [31:0] write_value;
	logic [31:0] hi_value;
	logic [31:0] lo_value;
	logic [1:0]  fault;

	modport source (output valid, write_valid, write_index, write_value,
		hi_value, lo_value, fault, input ready);
	modport sink (input valid, write_valid, write_index, write_value,
		hi_value, lo_value, fault, output ready);
endinterface

### hdl/mie_div.sv
// ----------------------------------------------------------------------------
// execute unit divider
// radix-2 restoring divider, one quotient bit per cycle, signed or unsigned
// ----------------------------------------------------------------------------
module mie_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mie_pkg::div_req_t  req,
	output mie_pkg::div_rsp_t  rsp
);
	import mie_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic        negq_q;
	logic        negr_q;
	logic [32:0] trial;
	logic        qbit;

	assign trial = {rem_q, dvd_q[31]} - {1'b0, dvs_q};
	assign qbit  = ~trial[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= (req.sgn && req.a[31]) ? (32'd0 - req.a) : req.a;
			dvs_q  <= (req.sgn && req.b[31]) ? (32'd0 - req.b) : req.b;
			rem_q  <= 32'd0;
			negq_q <= req.sgn & (req.a[31] ^ req.b[31]);
			negr_q <= req.sgn & req.a[31];
		end else if (busy_q) begin
			rem_q <= qbit ? trial[31:0] : {rem_q[30:0], dvd_q[31]};
			dvd_q <= {dvd_q[30:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = negq_q ? (32'd0 - dvd_q) : dvd_q;
	assign rsp.rem  = negr_q ? (32'd0 - rem_q) : rem_q;

endmodule

### hdl/mips_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// mips32 integer execute unit
// order of steps: register file read at accept, then the exec state, then the mul state
// for multiplies or the one-bit-per-cycle divider for divides, then writeback;
// a new instruction is accepted only once writeback has committed the last one;
// writeback also waits while the previous result beat is still held
// reset: register file valid bits, hi and lo cleared at once, no sweep
// ----------------------------------------------------------------------------
module mips_integer_execute_unit (
	input  logic          clk,
	input  logic          arst_n,
	mie_instr_if.sink     instr,
	mie_result_if.source  result
);
	import mie_pkg::*;

	function automatic logic [31:0] clz32(input logic [31:0] x);
		logic [5:0]  n;
		logic [31:0] v;
		n = 6'd0;
		v = x;
		if (v[31:16] == 16'd0) begin n = n + 6'd16; v = v << 16; end
		if (v[31:24] == 8'd0) begin n = n + 6'd8; v = v << 8; end
		if (v[31:28] == 4'd0) begin n = n + 6'd4; v = v << 4; end
		if (v[31:30] == 2'd0) begin n = n + 6'd2; v = v << 2; end
		if (v[31] == 1'b0) begin n = n + 6'd1; end
		if (x == 32'd0) n = 6'd32;
		return {26'd0, n};
	endfunction

	function automatic logic lt_s(input logic [31:0] x, input logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	state_t state_q, state_d;

	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic [31:0] rd_a_s1, rd_b_s1;
	logic        va_s1, vb_s1;
	logic        rf_we;

	logic [5:0]  kind_q;
	logic [4:0]  rt_q, rd_q, sh_q;
	logic [15:0] imm_q;
	logic [31:0] hi_q, lo_q;

	logic [31:0] a, b, se, zi;
	res_t        alu, res_q, fin, out_q;
	logic        out_v_q;
	logic        is_mul, is_div, msgn;
	logic [63:0] prod_s2, acc, macc;
	logic [32:0] ma33, mb33;
	logic [32:0] sum, dif, sumi;

	div_req_t    dreq;
	div_rsp_t    drsp;

	logic        accept, commit;

	assign accept = instr.valid & instr.ready;
	assign instr.ready = (state_q == S_IDLE);
	assign commit = (state_q == S_WB) && (!out_v_q || result.ready);

	// register file
	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[fin.widx] <= fin.wval;
		if (accept) begin
			rd_a_s1 <= rf_mem[instr.src_a_index];
			rd_b_s1 <= rf_mem[instr.src_b_index];
			va_s1   <= rf_vld_q[instr.src_a_index];
			vb_s1   <= rf_vld_q[instr.src_b_index];
			kind_q  <= instr.kind;
			rt_q    <= instr.src_b_index;
			rd_q    <= instr.dest_index;
			imm_q   <= instr.immediate;
			sh_q    <= instr.shift_amount;
		end
	end

	assign rf_we = commit & fin.wv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= 32'd0;
			hi_q     <= 32'd0;
			lo_q     <= 32'd0;
			out_v_q  <= 1'b0;
			state_q  <= S_IDLE;
		end else begin
			state_q <= state_d;
			if (rf_we) rf_vld_q[fin.widx] <= 1'b1;
			if (commit) begin
				hi_q    <= fin.hi;
				lo_q    <= fin.lo;
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign a  = va_s1 ? rd_a_s1 : 32'd0;
	assign b  = vb_s1 ? rd_b_s1 : 32'd0;
	assign se = {{16{imm_q[15]}}, imm_q};
	assign zi = {16'd0, imm_q};
	assign sum  = {1'b0, a} + {1'b0, b};
	assign dif  = {1'b0, a} - {1'b0, b};
	assign sumi = {1'b0, a} + {1'b0, se};

	always_comb begin
		alu        = '0;
		alu.hi     = hi_q;
		alu.lo     = lo_q;
		alu.fault  = F_NONE;
		is_mul     = 1'b0;
		is_div     = 1'b0;
		case (kind_q)
			K_ADDU:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = sum[31:0]; end
			K_ADD:   begin
				alu.wv = 1'b1; alu.widx = rd_q; alu.wval = sum[31:0];
				if (~(a[31] ^ b[31]) & (a[31] ^ sum[31])) alu.fault = F_OVF;
			end
			K_ADDIU: begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = sumi[31:0]; end
			K_ADDI:  begin
				alu.wv = 1'b1; alu.widx = rt_q; alu.wval = sumi[31:0];
				if (~(a[31] ^ se[31]) & (a[31] ^ sumi[31])) alu.fault = F_OVF;
			end
			K_AND:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = a & b; end
			K_ANDI:  begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = a & zi; end
			K_CLO:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = clz32(~a); end
			K_CLZ:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = clz32(a); end
			K_DIVU, K_DIV: begin
				if (b == 32'd0) alu.fault = F_DIVZ;
				else is_div = 1'b1;
			end
			K_MULT, K_MULTU, K_MADD, K_MADDU, K_MSUB, K_MSUBU: is_mul = 1'b1;
			K_MUL:   begin alu.wv = 1'b1; alu.widx = rd_q; is_mul = 1'b1; end
			K_NOR:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = ~(a | b); end
			K_OR:    begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = a | b; end
			K_ORI:   begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = a | zi; end
			K_SLL:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = b << sh_q; end
			K_SLLV:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = b << a[4:0]; end
			K_SRA:   begin
				alu.wv = 1'b1; alu.widx = rd_q; alu.wval = 32'($signed(b) >>> sh_q);
			end
			K_SRAV:  begin
				alu.wv = 1'b1; alu.widx = rd_q; alu.wval = 32'($signed(b) >>> a[4:0]);
			end
			K_SRL:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = b >> sh_q; end
			K_SRLV:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = b >> a[4:0]; end
			K_SUBU:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = dif[31:0]; end
			K_SUB:   begin
				alu.wv = 1'b1; alu.widx = rd_q; alu.wval = dif[31:0];
				if ((a[31] ^ b[31]) & (a[31] ^ dif[31])) alu.fault = F_OVF;
			end
			K_XOR:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = a ^ b; end
			K_XORI:  begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = a ^ zi; end
			K_LUI:   begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = {imm_q, 16'd0}; end
			K_SLTU:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = {31'd0, a < b}; end
			K_SLT:   begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = {31'd0, lt_s(a, b)}; end
			K_SLTIU: begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = {31'd0, a < se}; end
			K_SLTI:  begin alu.wv = 1'b1; alu.widx = rt_q; alu.wval = {31'd0, lt_s(a, se)}; end
			K_TEQ:   if (a == b) alu.fault = F_TRAP;
			K_TEQI:  if (a == se) alu.fault = F_TRAP;
			K_TNE:   if (a != b) alu.fault = F_TRAP;
			K_TNEI:  if (a != se) alu.fault = F_TRAP;
			K_TGEU:  if (a >= b) alu.fault = F_TRAP;
			K_TGEIU: if (a >= se) alu.fault = F_TRAP;
			K_TGE:   if (!lt_s(a, b)) alu.fault = F_TRAP;
			K_TGEI:  if (!lt_s(a, se)) alu.fault = F_TRAP;
			K_TLTU:  if (a < b) alu.fault = F_TRAP;
			K_TLTIU: if (a < se) alu.fault = F_TRAP;
			K_TLT:   if (lt_s(a, b)) alu.fault = F_TRAP;
			K_TLTI:  if (lt_s(a, se)) alu.fault = F_TRAP;
			K_MFHI:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = hi_q; end
			K_MFLO:  begin alu.wv = 1'b1; alu.widx = rd_q; alu.wval = lo_q; end
			K_MTHI:  alu.hi = a;
			K_MTLO:  alu.lo = a;
			default: ;
		endcase
	end

	// multiplier, registered product
	assign msgn = (kind_q == K_MULT) || (kind_q == K_MADD) || (kind_q == K_MSUB) ||
		(kind_q == K_MUL);
	assign ma33 = {msgn & a[31], a};
	assign mb33 = {msgn & b[31], b};

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) prod_s2 <= 64'($signed(ma33) * $signed(mb33));
	end

	assign acc  = {hi_q, lo_q};
	assign macc = ((kind_q == K_MADD) || (kind_q == K_MADDU)) ? acc + prod_s2
		: acc - prod_s2;

	assign dreq.start = (state_q == S_EXEC) & is_div;
	assign dreq.sgn   = (kind_q == K_DIV);
	assign dreq.a     = a;
	assign dreq.b     = b;

	mie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: res_q <= alu;
			S_MUL: begin
				if (kind_q == K_MUL) begin
					res_q.wval <= prod_s2[31:0];
				end else if ((kind_q == K_MULT) || (kind_q == K_MULTU)) begin
					res_q.hi <= prod_s2[63:32];
					res_q.lo <= prod_s2[31:0];
				end else begin
					res_q.hi <= macc[63:32];
					res_q.lo <= macc[31:0];
				end
			end
			S_DIV: if (drsp.done) begin
				res_q.lo <= drsp.quo;
				res_q.hi <= drsp.rem;
			end
			default: ;
		endcase
		if (commit) out_q <= fin;
	end

	always_comb begin
		fin = res_q;
		if (res_q.fault != F_NONE) begin
			fin.wv = 1'b0;
			fin.hi = hi_q;
			fin.lo = lo_q;
		end
		if (!fin.wv || (fin.widx == 5'd0)) begin
			fin.wv   = 1'b0;
			fin.widx = 5'd0;
			fin.wval = 32'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_EXEC;
			S_EXEC: begin
				if (is_div) state_d = S_DIV;
				else if (is_mul) state_d = S_MUL;
				else state_d = S_WB;
			end
			S_MUL:  state_d = S_WB;
			S_DIV:  if (drsp.done) state_d = S_WB;
			S_WB:   if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign result.valid       = out_v_q;
	assign result.write_valid = out_q.wv;
	assign result.write_index = out_q.widx;
	assign result.write_value = out_q.wval;
	assign result.hi_value    = out_q.hi;
	assign result.lo_value    = out_q.lo;
	assign result.fault       = out_q.fault;

	`include "mips_integer_execute_unit_assert.svh"

	`MIE_ASSERT_IMPL(a_fault_no_write, result.valid && (result.fault != F_NONE), !result.write_valid)
	`MIE_ASSERT_IMPL(a_no_zero_write, result.valid && result.write_valid, result.write_index != 5'd0)
	`MIE_ASSERT_IMPL(a_div_state_kind, state_q == S_DIV, (kind_q == K_DIV) || (kind_q == K_DIVU))
	`MIE_ASSERT_NEVER(a_rf_zero_valid, rf_vld_q[0])

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// execute unit testbench
// drives decoded integer instructions into the execute unit, predicts the
// register write, hi, lo and fault of each one from a private copy of the
// register file, and compares every result beat in order
// ----------------------------------------------------------------------------
module testbench;
	import mie_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;

	mie_instr_if  instr ();
	mie_result_if result ();

	mips_integer_execute_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr.sink),
		.result (result.source)
	);

	typedef struct {
		logic [5:0]  kind;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [4:0]  rd;
		logic [15:0] imm;
		logic [4:0]  sh;
	} instr_t;

	logic [31:0] gpr [32];
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	res_t        pending_results [$];
	int          mismatches;
	int          cycles;
	int          hold_off;
	bit          fill_mode;
	bit          rx_took;
	int          rx_wait;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [5:0] lead_zeros(logic [31:0] x);
		for (int i = 31; i >= 0; i--)
			if (x[i])
				return 6'(31 - i);
		return 6'd32;
	endfunction

	function automatic res_t execute(instr_t op);
		logic [31:0] a, b, se, ze, r, q, m, ma, mb;
		logic [63:0] p, acc;
		res_t        o;
		logic        wv, trap;
		logic [4:0]  wi;
		logic [31:0] nhi, nlo;
		a = gpr[op.ra];
		b = gpr[op.rb];
		se = {{16{op.imm[15]}}, op.imm};
		ze = {16'h0, op.imm};
		acc = {hi_q, lo_q};
		wv = 1'b0; wi = 5'd0; r = '0; trap = 1'b0;
		nhi = hi_q; nlo = lo_q;
		o.fault = F_NONE;
		case (op.kind)
			K_ADDU: begin wv = 1; wi = op.rd; r = a + b; end
			K_ADD: begin
				wv = 1; wi = op.rd; r = a + b;
				if (a[31] == b[31] && r[31] != a[31]) o.fault = F_OVF;
			end
			K_ADDIU: begin wv = 1; wi = op.rb; r = a + se; end
			K_ADDI: begin
				wv = 1; wi = op.rb; r = a + se;
				if (a[31] == se[31] && r[31] != a[31]) o.fault = F_OVF;
			end
			K_AND:  begin wv = 1; wi = op.rd; r = a & b; end
			K_ANDI: begin wv = 1; wi = op.rb; r = a & ze; end
			K_CLO:  begin wv = 1; wi = op.rd; r = 32'(lead_zeros(~a)); end
			K_CLZ:  begin wv = 1; wi = op.rd; r = 32'(lead_zeros(a)); end
			K_DIVU: begin
				if (b == 0) o.fault = F_DIVZ;
				else begin nlo = a / b; nhi = a % b; end
			end
			K_DIV: begin
				if (b == 0) o.fault = F_DIVZ;
				else begin
					ma = a[31] ? -a : a;
					mb = b[31] ? -b : b;
					q = ma / mb; m = ma % mb;
					if (a[31] ^ b[31]) q = -q;
					if (a[31]) m = -m;
					nlo = q; nhi = m;
				end
			end
			K_MULT: begin p = $signed(64'($signed(a))) * $signed(64'($signed(b)));
				{nhi, nlo} = p; end
			K_MULTU: begin p = 64'(a) * 64'(b); {nhi, nlo} = p; end
			K_MUL: begin wv = 1; wi = op.rd; r = a * b; end
			K_MADD, K_MADDU, K_MSUB, K_MSUBU: begin
				if (op.kind == K_MADD || op.kind == K_MSUB)
					p = 64'($signed(a)) * 64'($signed(b));
				else
					p = 64'(a) * 64'(b);
				{nhi, nlo} = (op.kind == K_MADD || op.kind == K_MADDU) ? acc + p : acc - p;
			end
			K_NOR:  begin wv = 1; wi = op.rd; r = ~(a | b); end
			K_OR:   begin wv = 1; wi = op.rd; r = a | b; end
			K_ORI:  begin wv = 1; wi = op.rb; r = a | ze; end
			K_SLL:  begin wv = 1; wi = op.rd; r = b << op.sh; end
			K_SLLV: begin wv = 1; wi = op.rd; r = b << a[4:0]; end
			K_SRA:  begin wv = 1; wi = op.rd; r = $signed(b) >>> op.sh; end
			K_SRAV: begin wv = 1; wi = op.rd; r = $signed(b) >>> a[4:0]; end
			K_SRL:  begin wv = 1; wi = op.rd; r = b >> op.sh; end
			K_SRLV: begin wv = 1; wi = op.rd; r = b >> a[4:0]; end
			K_SUBU: begin wv = 1; wi = op.rd; r = a - b; end
			K_SUB: begin
				wv = 1; wi = op.rd; r = a - b;
				if (a[31] != b[31] && r[31] != a[31]) o.fault = F_OVF;
			end
			K_XOR:   begin wv = 1; wi = op.rd; r = a ^ b; end
			K_XORI:  begin wv = 1; wi = op.rb; r = a ^ ze; end
			K_LUI:   begin wv = 1; wi = op.rb; r = {op.imm, 16'h0}; end
			K_SLTU:  begin wv = 1; wi = op.rd; r = 32'(a < b); end
			K_SLT:   begin wv = 1; wi = op.rd; r = 32'($signed(a) < $signed(b)); end
			K_SLTIU: begin wv = 1; wi = op.rb; r = 32'(a < se); end
			K_SLTI:  begin wv = 1; wi = op.rb; r = 32'($signed(a) < $signed(se)); end
			K_TEQ:   trap = a == b;
			K_TEQI:  trap = a == se;
			K_TNE:   trap = a != b;
			K_TNEI:  trap = a != se;
			K_TGEU:  trap = a >= b;
			K_TGEIU: trap = a >= se;
			K_TGE:   trap = $signed(a) >= $signed(b);
			K_TGEI:  trap = $signed(a) >= $signed(se);
			K_TLTU:  trap = a < b;
			K_TLTIU: trap = a < se;
			K_TLT:   trap = $signed(a) < $signed(b);
			K_TLTI:  trap = $signed(a) < $signed(se);
			K_MFHI:  begin wv = 1; wi = op.rd; r = hi_q; end
			K_MFLO:  begin wv = 1; wi = op.rd; r = lo_q; end
			K_MTHI:  nhi = a;
			K_MTLO:  nlo = a;
			default: ;
		endcase
		if (trap) o.fault = F_TRAP;
		if (o.fault != F_NONE) begin
			wv = 0; nhi = hi_q; nlo = lo_q;
		end
		if (!wv || wi == 0) begin
			wv = 0; wi = 0; r = 0;
		end else
			gpr[wi] = r;
		hi_q = nhi;
		lo_q = nlo;
		o.wv = wv; o.widx = wi; o.wval = r; o.hi = hi_q; o.lo = lo_q;
		return o;
	endfunction

	// one beat on the instruction channel, prediction made at acceptance
	task automatic send(instr_t op);
		int unsigned gap;
		gap = fill_mode ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			instr.valid <= 1'b0;
			repeat (gap)
				@(negedge clk);
		end
		instr.valid <= 1'b1;
		instr.kind <= op.kind;
		instr.src_a_index <= op.ra;
		instr.src_b_index <= op.rb;
		instr.dest_index <= op.rd;
		instr.immediate <= op.imm;
		instr.shift_amount <= op.sh;
		do @(posedge clk); while (!instr.ready);
		pending_results.push_back(execute(op));
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return 32'h80000000;
			3: return 32'h7FFFFFFF;
			4: return 32'(1);
			5: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t make(logic [5:0] k, logic [4:0] ra, logic [4:0] rb,
		logic [4:0] rd, logic [15:0] imm, logic [4:0] sh);
		instr_t op;
		op.kind = k; op.ra = ra; op.rb = rb; op.rd = rd; op.imm = imm; op.sh = sh;
		return op;
	endfunction

	// load a register through lui and ori
	task automatic load_reg(logic [4:0] idx, logic [31:0] v);
		send(make(K_LUI, 5'd0, idx, 5'd0, v[31:16], 5'd0));
		send(make(K_ORI, idx, idx, 5'd0, v[15:0], 5'd0));
	endtask

	task automatic test_directed();
		load_reg(5'd1, 32'h80000000);
		load_reg(5'd2, 32'hFFFFFFFF);
		load_reg(5'd3, 32'h7FFFFFFF);
		send(make(K_ADD, 5'd3, 5'd3, 5'd4, 16'h0, 5'd0));
		send(make(K_SUB, 5'd1, 5'd3, 5'd4, 16'h0, 5'd0));
		send(make(K_ADDI, 5'd3, 5'd4, 5'd0, 16'h0001, 5'd0));
		send(make(K_DIV, 5'd1, 5'd2, 5'd0, 16'h0, 5'd0));
		send(make(K_DIVU, 5'd1, 5'd0, 5'd0, 16'h0, 5'd0));
		send(make(K_DIV, 5'd2, 5'd3, 5'd0, 16'h0, 5'd0));
		send(make(K_MFHI, 5'd0, 5'd0, 5'd5, 16'h0, 5'd0));
		send(make(K_MULT, 5'd1, 5'd1, 5'd0, 16'h0, 5'd0));
		send(make(K_MADDU, 5'd2, 5'd2, 5'd0, 16'h0, 5'd0));
		send(make(K_MSUB, 5'd1, 5'd2, 5'd0, 16'h0, 5'd0));
		send(make(K_ADDU, 5'd2, 5'd2, 5'd0, 16'h0, 5'd0));
		send(make(K_SRAV, 5'd2, 5'd1, 5'd6, 16'h0, 5'd0));
		send(make(K_SRA, 5'd0, 5'd1, 5'd6, 16'h0, 5'd31));
		send(make(K_CLZ, 5'd0, 5'd0, 5'd7, 16'h0, 5'd0));
		send(make(K_CLO, 5'd2, 5'd0, 5'd7, 16'h0, 5'd0));
		send(make(K_TEQI, 5'd2, 5'd0, 5'd0, 16'hFFFF, 5'd0));
		send(make(K_TLT, 5'd1, 5'd3, 5'd0, 16'h0, 5'd0));
		send(make(6'd63, 5'd31, 5'd31, 5'd31, 16'hFFFF, 5'd31));
	endtask

	task automatic test_random(int count);
		instr_t op;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				op.ra = 5'($urandom); op.rb = 5'($urandom);
				load_reg(op.rb, pick_value());
				continue;
			end
			op.kind = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(51, 63))
				: 6'($urandom_range(0, 50));
			op.ra = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
			op.rb = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
			op.rd = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
			op.imm = 16'($urandom);
			op.sh = 5'($urandom);
			send(op);
		end
	endtask

	task automatic test_backpressure();
		hold_off = 200;
		fill_mode = 1;
		for (int i = 0; i < 8; i++)
			send(make(K_ADDU, 5'($urandom), 5'($urandom), 5'($urandom), 16'h0, 5'd0));
		fill_mode = 0;
	endtask

	// result side: random wait per beat, long hold-off on request
	always @(negedge clk) begin
		if (rx_took)
			rx_wait = $urandom_range(0, 10);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			result.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			result.ready <= 1'b0;
		end else
			result.ready <= 1'b1;
	end

	always @(posedge clk) begin
		res_t want;
		rx_took <= arst_n && result.valid && result.ready;
		if (arst_n && result.valid && result.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat");
			end else begin
				want = pending_results.pop_front();
				if (want.wv !== result.write_valid || want.widx !== result.write_index
						|| want.wval !== result.write_value || want.hi !== result.hi_value
						|| want.lo !== result.lo_value || want.fault !== result.fault) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp wv=%0d idx=%0d val=%h hi=%h lo=%h f=%0d",
							want.wv, want.widx, want.wval, want.hi, want.lo, want.fault);
						$display("         got wv=%0d idx=%0d val=%h hi=%h lo=%h f=%0d",
							result.write_valid, result.write_index, result.write_value,
							result.hi_value, result.lo_value, result.fault);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 32; i++) gpr[i] = '0;
		hi_q = '0; lo_q = '0;
		mismatches = 0; cycles = 0; hold_off = 0; fill_mode = 0;
		arst_n = 1'b0;
		instr.valid = 1'b0;
		instr.kind = '0; instr.src_a_index = '0; instr.src_b_index = '0;
		instr.dest_index = '0; instr.immediate = '0; instr.shift_amount = '0;
		result.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(700);
		instr.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
